// File: rtl/tkps_pkg.sv
// Shared types, constants and helper functions of the top-k pair score selector.
`timescale 1ns / 1ps
package tkps_pkg;

   localparam int K_MAX       = 3;
   localparam int MAX_DIM     = 64;
   localparam int SCORE_W     = 16;
   localparam int IDX_W       = 6;
   localparam int CFG_W       = 7;
   localparam int RANK_W      = 2;
   localparam int FILL_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [CSR_IDX_W-1:0] REG_PAIR_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COL_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SKIP_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_K      = 3'd4;

   typedef struct packed {
      logic             pair_mode;
      logic [CFG_W-1:0] row_count;
      logic [CFG_W-1:0] col_count;
      logic [CFG_W-1:0] skip_count;
      logic [1:0]       top_k;
   } cfg_type;

   // One classified score on its way from the front to the back.
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               qualify;
      logic [IDX_W-1:0]   first_index;
      logic [IDX_W-1:0]   second_index;
      logic               last_item;
   } entry_type;

   // Dimension of 0 counts as 1, anything above MAX_DIM as MAX_DIM.
   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > CFG_W'(MAX_DIM)) begin
         r = CFG_W'(MAX_DIM);
      end
      return r;
   endfunction

   function automatic logic [FILL_W-1:0] eff_top(input logic [1:0] v);
      logic [FILL_W-1:0] r;
      r = FILL_W'(v);
      if (v == '0) begin
         r = FILL_W'(1);
      end else if (v > 2'(K_MAX)) begin
         r = FILL_W'(K_MAX);
      end
      return r;
   endfunction

endpackage

// File: rtl/tkps_front.sv
// Front part: position tracking and qualification of each incoming score.
`timescale 1ns / 1ps
module tkps_front
   import tkps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               push,
   input  logic [SCORE_W-1:0] score,
   input  logic               last_item,
   output entry_type          entry
);

   logic [IDX_W-1:0] row_pos_ff, row_pos_in;
   logic [IDX_W-1:0] col_pos_ff, col_pos_in;
   logic [CFG_W-1:0] rows;
   logic [CFG_W-1:0] cols;
   logic [IDX_W-1:0] row_eff;
   logic [IDX_W-1:0] col_eff;
   logic [CFG_W-1:0] col_inc;
   logic [CFG_W-1:0] row_inc;
   logic [CFG_W-1:0] shifted;

   always_comb begin
      rows    = clamp_dim(cfg.row_count);
      cols    = clamp_dim(cfg.col_count);
      // wrap positions that fall outside the current shape
      col_eff = ({1'b0, col_pos_ff} >= cols) ? '0 : col_pos_ff;
      row_eff = ({1'b0, row_pos_ff} >= rows) ? '0 : row_pos_ff;
      col_inc = {1'b0, col_eff} + CFG_W'(1);
      row_inc = {1'b0, row_eff} + CFG_W'(1);
      shifted = {1'b0, col_eff} - cfg.skip_count;

      entry.score     = score;
      entry.last_item = last_item;
      if (cfg.pair_mode) begin
         entry.qualify      = col_eff > row_eff;
         entry.first_index  = row_eff;
         entry.second_index = col_eff;
      end else begin
         entry.qualify      = {1'b0, col_eff} >= cfg.skip_count;
         entry.first_index  = shifted[IDX_W-1:0];
         entry.second_index = '0;
      end

      if (col_inc >= cols) begin
         col_pos_in = '0;
         if (cfg.pair_mode && (row_inc < rows)) begin
            row_pos_in = row_inc[IDX_W-1:0];
         end else begin
            row_pos_in = '0;
         end
      end else begin
         col_pos_in = col_inc[IDX_W-1:0];
         row_pos_in = row_eff;
      end
      // a run ends with its last item: restart at the origin
      if (last_item) begin
         col_pos_in = '0;
         row_pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
      end else if (push) begin
         row_pos_ff <= row_pos_in;
         col_pos_ff <= col_pos_in;
      end
   end

endmodule

// File: rtl/tkps_queue.sv
// Short queue of classified entries between the front and the back.
`timescale 1ns / 1ps
module tkps_queue
   import tkps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head
);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push;
   logic               do_pop;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

// File: rtl/tkps_back.sv
// Back part: parallel top-k insert and result emission buffer.
`timescale 1ns / 1ps
module tkps_back
   import tkps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               head_valid,
   input  entry_type          head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SCORE_W-1:0] rsp_best_score,
   output logic [IDX_W-1:0]   rsp_first_index,
   output logic [IDX_W-1:0]   rsp_second_index,
   output logic [RANK_W-1:0]  rsp_rank,
   output logic               rsp_empty_res,
   output logic               rsp_last_result
);

   logic [SCORE_W-1:0] kept_score_ff [K_MAX];
   logic [IDX_W-1:0]   kept_row_ff   [K_MAX];
   logic [IDX_W-1:0]   kept_col_ff   [K_MAX];
   logic [FILL_W-1:0]  kept_fill_ff;

   logic [SCORE_W-1:0] kept_score_in [K_MAX];
   logic [IDX_W-1:0]   kept_row_in   [K_MAX];
   logic [IDX_W-1:0]   kept_col_in   [K_MAX];
   logic [FILL_W-1:0]  kept_fill_in;

   logic [SCORE_W-1:0] emit_score_ff [K_MAX];
   logic [IDX_W-1:0]   emit_row_ff   [K_MAX];
   logic [IDX_W-1:0]   emit_col_ff   [K_MAX];
   logic [FILL_W-1:0]  emit_cnt_ff;
   logic [RANK_W-1:0]  emit_idx_ff;
   logic               emit_busy_ff;

   logic [FILL_W-1:0]  k;
   logic [FILL_W-1:0]  n;
   logic [FILL_W-1:0]  tail;
   logic [FILL_W-1:0]  p;
   logic [FILL_W-1:0]  n_out;
   logic [K_MAX-1:0]   ge;
   logic               run;
   logic               insert;
   logic               rsp_take;
   logic               emit_empty;

   // a last item may refill the snapshot in the cycle its final result leaves
   assign pop      = head_valid &&
                     (!head.last_item || !emit_busy_ff || (rsp_take && rsp_last_result));
   assign rsp_take = emit_busy_ff && !rsp_stall;

   always_comb begin
      k    = eff_top(cfg.top_k);
      n    = (kept_fill_ff < k) ? kept_fill_ff : k;
      tail = (n < k) ? n : (k - FILL_W'(1));
      for (int i = 0; i < K_MAX; i++) begin
         ge[i] = (FILL_W'(i) < n) && (kept_score_ff[i] >= head.score);
      end
      // insertion slot = number of leading kept scores not below the new one
      run = 1'b1;
      p   = '0;
      for (int i = 0; i < K_MAX; i++) begin
         if (run && ge[i]) begin
            p = p + FILL_W'(1);
         end else begin
            run = 1'b0;
         end
      end
      insert = head.qualify && (p < k);

      for (int i = 0; i < K_MAX; i++) begin
         kept_score_in[i] = kept_score_ff[i];
         kept_row_in[i]   = kept_row_ff[i];
         kept_col_in[i]   = kept_col_ff[i];
         if (insert) begin
            if (FILL_W'(i) == p) begin
               kept_score_in[i] = head.score;
               kept_row_in[i]   = head.first_index;
               kept_col_in[i]   = head.second_index;
            end else if (i > 0) begin
               if ((FILL_W'(i) > p) && (FILL_W'(i) <= tail)) begin
                  kept_score_in[i] = kept_score_ff[i-1];
                  kept_row_in[i]   = kept_row_ff[i-1];
                  kept_col_in[i]   = kept_col_ff[i-1];
               end
            end
         end
      end
      kept_fill_in = insert ? ((n < k) ? (n + FILL_W'(1)) : k) : kept_fill_ff;
      n_out        = (kept_fill_in < k) ? kept_fill_in : k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < K_MAX; i++) begin
            kept_score_ff[i] <= '0;
            kept_row_ff[i]   <= '0;
            kept_col_ff[i]   <= '0;
         end
         kept_fill_ff <= '0;
      end else if (pop) begin
         if (head.last_item) begin
            for (int i = 0; i < K_MAX; i++) begin
               kept_score_ff[i] <= '0;
               kept_row_ff[i]   <= '0;
               kept_col_ff[i]   <= '0;
            end
            kept_fill_ff <= '0;
         end else begin
            for (int i = 0; i < K_MAX; i++) begin
               kept_score_ff[i] <= kept_score_in[i];
               kept_row_ff[i]   <= kept_row_in[i];
               kept_col_ff[i]   <= kept_col_in[i];
            end
            kept_fill_ff <= kept_fill_in;
         end
      end
   end

   // snapshot of a finished run; drained one rank per accepted item
   always_ff @(posedge clock) begin
      if (pop && head.last_item) begin
         for (int i = 0; i < K_MAX; i++) begin
            emit_score_ff[i] <= kept_score_in[i];
            emit_row_ff[i]   <= kept_row_in[i];
            emit_col_ff[i]   <= kept_col_in[i];
         end
         emit_cnt_ff <= n_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_busy_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else if (pop && head.last_item) begin
         emit_busy_ff <= 1'b1;
         emit_idx_ff  <= '0;
      end else if (rsp_take) begin
         if (rsp_last_result) begin
            emit_busy_ff <= 1'b0;
            emit_idx_ff  <= '0;
         end else begin
            emit_idx_ff <= emit_idx_ff + RANK_W'(1);
         end
      end
   end

   assign emit_empty       = emit_cnt_ff == '0;
   assign rsp_valid        = emit_busy_ff;
   assign rsp_empty_res    = emit_empty;
   assign rsp_rank         = emit_idx_ff;
   assign rsp_last_result  = emit_empty || (FILL_W'(emit_idx_ff) == (emit_cnt_ff - FILL_W'(1)));
   assign rsp_best_score   = emit_empty ? '0 : emit_score_ff[emit_idx_ff];
   assign rsp_first_index  = emit_empty ? '0 : emit_row_ff[emit_idx_ff];
   assign rsp_second_index = emit_empty ? '0 : emit_col_ff[emit_idx_ff];

endmodule

// File: rtl/top_k_pair_score_selector.sv
// Top level of the top-k pair score selector: registers, front, queue and back.
`timescale 1ns / 1ps
// Usage:
//   req_*  : one Q0.16 score per item; req_last_item closes a run. Accepted at a
//            clock edge with req_valid high and req_stall low.
//   rsp_*  : results of a run, best first, ranked 0..top_k-1; rsp_last_result
//            marks the final one. An empty run gives one item with rsp_empty_res.
//   csr_*  : register writes (index, 7-bit data); csr_ready is always high.
//            Write only while no run is in flight.
// Throughput: one score per cycle while req_stall is low. The front classifies each
//   score by its row/column position, a four-entry queue decouples it from the
//   back, which inserts into the three kept slots in parallel.
// Results: rsp_valid is registered and rises once the back has popped the last
//   item of a run from the queue. A run's results drain one per cycle, unless
//   rsp_stall holds them, from a snapshot buffer while the next run streams in;
//   the next last item waits until the final result of that buffer is taken.
// Stall: a stalled result holds; backpressure fills the queue and then raises
//   req_stall.
// Reset: synchronous, active high; registers return to pair mode, 64 x 64,
//   skip 0, top 3, and all run state is cleared.
module top_k_pair_score_selector
   import tkps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SCORE_W-1:0]   req_score,
   input  logic                 req_last_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SCORE_W-1:0]   rsp_best_score,
   output logic [IDX_W-1:0]     rsp_first_index,
   output logic [IDX_W-1:0]     rsp_second_index,
   output logic [RANK_W-1:0]    rsp_rank,
   output logic                 rsp_empty_res,
   output logic                 rsp_last_result,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type   cfg_ff;
   entry_type front_entry;
   entry_type head;
   logic      q_full;
   logic      q_head_valid;
   logic      q_pop;
   logic      push;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // register file: unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pair_mode  <= 1'b1;
         cfg_ff.row_count  <= CFG_W'(MAX_DIM);
         cfg_ff.col_count  <= CFG_W'(MAX_DIM);
         cfg_ff.skip_count <= '0;
         cfg_ff.top_k      <= 2'(K_MAX);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PAIR_MODE:  cfg_ff.pair_mode  <= csr_wdata[0];
            REG_ROW_COUNT:  cfg_ff.row_count  <= csr_wdata;
            REG_COL_COUNT:  cfg_ff.col_count  <= csr_wdata;
            REG_SKIP_COUNT: cfg_ff.skip_count <= csr_wdata;
            REG_TOP_K:      cfg_ff.top_k      <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   tkps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .push      (push),
      .score     (req_score),
      .last_item (req_last_item),
      .entry     (front_entry)
   );

   tkps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (head)
   );

   tkps_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (q_head_valid),
      .head             (head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_best_score   (rsp_best_score),
      .rsp_first_index  (rsp_first_index),
      .rsp_second_index (rsp_second_index),
      .rsp_rank         (rsp_rank),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_last_result  (rsp_last_result)
   );

endmodule
